// ===== rtl/ptd_pkg.sv =====
// Shared types, codes and constants for the priority timer dispatcher.
`timescale 1ns / 1ps
`default_nettype none

package ptd_pkg;

    localparam int MAX_HANDLERS_DEF = 16;
    localparam int TIME_BITS_DEF    = 48;
    localparam int MAX_RESULTS      = 16;
    localparam int RES_CNT_W        = $clog2(MAX_RESULTS + 1);

    // One day in microseconds; fits in DAY_BITS bits.
    localparam logic [63:0] DAY_US   = 64'd24 * 64'd60 * 64'd60 * 64'd1000000;
    localparam int          DAY_BITS = 37;

    localparam logic [1:0] FUNC_ADD     = 2'd0;
    localparam logic [1:0] FUNC_RESCHED = 2'd1;
    localparam logic [1:0] FUNC_POLL    = 2'd2;
    localparam logic [1:0] FUNC_QUERY   = 2'd3;

    localparam logic [2:0] KIND_ADDED     = 3'd0;
    localparam logic [2:0] KIND_RESCHED   = 3'd1;
    localparam logic [2:0] KIND_DUE       = 3'd2;
    localparam logic [2:0] KIND_NONE_DUE  = 3'd3;
    localparam logic [2:0] KIND_NEXT_WAKE = 3'd4;
    localparam logic [2:0] KIND_ERROR     = 3'd5;

    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  handler_id;
        logic [7:0]  priority_req;
        logic [47:0] event_time;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [3:0]  result_id;
        logic [47:0] wake_time;
        logic        table_empty;
        logic        last;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EMIT,
        S_ADD_SHIFT,
        S_ADD_PUT,
        S_SC_ORD,
        S_SC_CMP,
        S_POLL_END,
        S_Q_END
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/ptd_engine.sv =====
// Handler table engine: order and activation memories with the operation sequencer.
`timescale 1ns / 1ps
`default_nettype none

module ptd_engine import ptd_pkg::*; #(
    parameter int MAX_HANDLERS = MAX_HANDLERS_DEF,
    parameter int TIME_BITS    = TIME_BITS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    input  wire t_in_item  i_item,
    output logic           o_ready,
    output logic           o_res_valid,
    output t_out_item      o_res,
    input  wire logic      i_res_ready
);

    localparam int IDW  = $clog2(MAX_HANDLERS);
    localparam int CNTW = $clog2(MAX_HANDLERS + 1);
    localparam int OW   = IDW + 8;
    localparam int NXW  = ((TIME_BITS > DAY_BITS) ? TIME_BITS : DAY_BITS) + 1;

    localparam logic [NXW-1:0] TMASK    = NXW'({TIME_BITS{1'b1}});
    localparam logic [NXW-1:0] DAY_EXT  = NXW'(DAY_US);
    localparam bit             DAY_FITS = (DAY_EXT <= TMASK);

    // order table: {id, prio} by descending priority; activation times by id
    logic [OW-1:0]        mem_ord [MAX_HANDLERS];
    logic [TIME_BITS-1:0] mem_act [MAX_HANDLERS];

    t_state               r_state, n_state;
    logic [CNTW-1:0]      r_count, n_count;
    logic [1:0]           r_func, n_func;
    logic [TIME_BITS-1:0] r_time, n_time;
    logic [7:0]           r_prio, n_prio;
    logic [IDW-1:0]       r_new_id, n_new_id;
    logic [IDW-1:0]       r_idx, n_idx;
    logic [IDW-1:0]       r_cur_id, n_cur_id;
    logic                 r_pend, n_pend;
    logic [IDW-1:0]       r_pend_id, n_pend_id;
    logic [RES_CNT_W-1:0] r_cnt, n_cnt;
    logic [NXW-1:0]       r_next, n_next;
    t_out_item            r_single, n_single;
    logic [OW-1:0]        r_ord_rd;
    logic [TIME_BITS-1:0] r_act_rd;

    logic                 ord_we;
    logic [IDW-1:0]       ord_waddr;
    logic [OW-1:0]        ord_wdata;
    logic                 act_we;
    logic [IDW-1:0]       act_waddr;
    logic [TIME_BITS-1:0] act_wdata;
    logic                 act_re;

    logic [TIME_BITS-1:0] t_in;
    logic [NXW-1:0]       day_sum;
    logic [NXW-1:0]       start_next;
    logic                 full;
    logic                 hid_ok;
    logic [7:0]           rd_prio;
    logic [IDW-1:0]       rd_id;
    logic                 due;
    logic                 q_less;
    logic                 last_idx;
    logic [RES_CNT_W-1:0] cnt_inc;
    logic                 is_poll;
    logic [NXW-1:0]       wake_final;

    assign t_in       = TIME_BITS'(i_item.event_time);
    assign day_sum    = NXW'(t_in) + DAY_EXT;
    // saturate at the top of the time range only when a day fits in it
    assign start_next = (DAY_FITS && (day_sum > TMASK)) ? TMASK : day_sum;
    assign full       = (r_count == CNTW'(MAX_HANDLERS));
    assign hid_ok     = ({{CNTW{1'b0}}, i_item.handler_id} < {4'b0000, r_count});
    assign rd_prio    = r_ord_rd[7:0];
    assign rd_id      = r_ord_rd[OW-1:8];
    assign due        = (r_act_rd < r_time);
    assign q_less     = (NXW'(r_act_rd) < r_next);
    assign last_idx   = (r_idx == IDW'(r_count - 1'b1));
    assign cnt_inc    = r_cnt + 1'b1;
    assign is_poll    = (r_func == FUNC_POLL);
    assign wake_final = (r_next < NXW'(r_time)) ? NXW'(r_time) : r_next;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    unique case (i_item.func)
                        FUNC_ADD: begin
                            if (full) begin
                                n_state = S_EMIT;
                            end else if (r_count == '0) begin
                                n_state = S_ADD_PUT;
                            end else begin
                                n_state = S_ADD_SHIFT;
                            end
                        end
                        FUNC_RESCHED: n_state = S_EMIT;
                        FUNC_POLL, FUNC_QUERY: begin
                            n_state = (r_count == '0) ? S_EMIT : S_SC_ORD;
                        end
                    endcase
                end
            end
            S_EMIT, S_POLL_END, S_Q_END: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            S_ADD_SHIFT: begin
                if (rd_prio >= r_prio) begin
                    n_state = S_EMIT;
                end else if (r_idx == '0) begin
                    n_state = S_ADD_PUT;
                end
            end
            S_ADD_PUT: n_state = S_EMIT;
            S_SC_ORD:  n_state = S_SC_CMP;
            S_SC_CMP: begin
                if (is_poll) begin
                    if (due && r_pend && !i_res_ready) begin
                        n_state = S_SC_CMP;
                    end else if (last_idx || (due && (cnt_inc == RES_CNT_W'(MAX_RESULTS)))) begin
                        n_state = S_POLL_END;
                    end else begin
                        n_state = S_SC_ORD;
                    end
                end else begin
                    n_state = last_idx ? S_Q_END : S_SC_ORD;
                end
            end
        endcase
    end

    // outputs, memory controls and datapath
    always_comb begin
        o_ready     = 1'b0;
        o_res_valid = 1'b0;
        o_res       = r_single;
        ord_we      = 1'b0;
        ord_waddr   = '0;
        ord_wdata   = r_ord_rd;
        act_we      = 1'b0;
        act_waddr   = '0;
        act_wdata   = t_in;
        act_re      = 1'b0;
        n_count     = r_count;
        n_func      = r_func;
        n_time      = r_time;
        n_prio      = r_prio;
        n_new_id    = r_new_id;
        n_idx       = r_idx;
        n_cur_id    = r_cur_id;
        n_pend      = r_pend;
        n_pend_id   = r_pend_id;
        n_cnt       = r_cnt;
        n_next      = r_next;
        n_single    = r_single;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_func   = i_item.func;
                    n_time   = t_in;
                    n_prio   = i_item.priority_req;
                    n_next   = start_next;
                    n_idx    = '0;
                    n_pend   = 1'b0;
                    n_cnt    = '0;
                    n_single = '{result_kind: KIND_ERROR, result_id: 4'd0, wake_time: 48'd0,
                                 table_empty: 1'b0, last: 1'b1};
                    unique case (i_item.func)
                        FUNC_ADD: begin
                            if (!full) begin
                                act_we    = 1'b1;
                                act_waddr = IDW'(r_count);
                                n_count   = r_count + 1'b1;
                                n_new_id  = IDW'(r_count);
                                n_idx     = IDW'(r_count - 1'b1);
                                n_single.result_kind = KIND_ADDED;
                                n_single.result_id   = 4'(r_count);
                            end
                        end
                        FUNC_RESCHED: begin
                            n_single.result_id = i_item.handler_id;
                            if (hid_ok) begin
                                act_we    = 1'b1;
                                act_waddr = IDW'(i_item.handler_id);
                                n_single.result_kind = KIND_RESCHED;
                            end
                        end
                        FUNC_POLL: begin
                            n_single.result_kind = KIND_NONE_DUE;
                        end
                        FUNC_QUERY: begin
                            n_single.result_kind = KIND_NEXT_WAKE;
                            n_single.table_empty = 1'b1;
                        end
                    endcase
                end
            end
            S_EMIT: begin
                o_res_valid = 1'b1;
            end
            S_ADD_SHIFT: begin
                // walk down from the tail, moving lower priorities up one slot
                ord_we    = 1'b1;
                ord_waddr = r_idx + 1'b1;
                if (rd_prio >= r_prio) begin
                    ord_wdata = {r_new_id, r_prio};
                end else begin
                    ord_wdata = r_ord_rd;
                    n_idx     = r_idx - 1'b1;
                end
            end
            S_ADD_PUT: begin
                ord_we    = 1'b1;
                ord_waddr = '0;
                ord_wdata = {r_new_id, r_prio};
            end
            S_SC_ORD: begin
                act_re   = 1'b1;
                n_cur_id = rd_id;
            end
            S_SC_CMP: begin
                if (is_poll) begin
                    // one due id is held back so the final one can carry last
                    if (due) begin
                        if (r_pend) begin
                            o_res_valid = 1'b1;
                            o_res = '{result_kind: KIND_DUE, result_id: 4'(r_pend_id),
                                      wake_time: 48'd0, table_empty: 1'b0, last: 1'b0};
                            if (i_res_ready) begin
                                n_pend_id = r_cur_id;
                                n_cnt     = cnt_inc;
                                n_idx     = r_idx + 1'b1;
                            end
                        end else begin
                            n_pend    = 1'b1;
                            n_pend_id = r_cur_id;
                            n_cnt     = cnt_inc;
                            n_idx     = r_idx + 1'b1;
                        end
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end else begin
                    if (q_less) begin
                        n_next = NXW'(r_act_rd);
                    end
                    n_idx = r_idx + 1'b1;
                end
            end
            S_POLL_END: begin
                o_res_valid = 1'b1;
                if (r_pend) begin
                    o_res = '{result_kind: KIND_DUE, result_id: 4'(r_pend_id),
                              wake_time: 48'd0, table_empty: 1'b0, last: 1'b1};
                end else begin
                    o_res = '{result_kind: KIND_NONE_DUE, result_id: 4'd0,
                              wake_time: 48'd0, table_empty: 1'b0, last: 1'b1};
                end
            end
            S_Q_END: begin
                o_res_valid = 1'b1;
                o_res = '{result_kind: KIND_NEXT_WAKE, result_id: 4'd0,
                          wake_time: 48'(wake_final), table_empty: 1'b0, last: 1'b1};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func    <= n_func;
        r_time    <= n_time;
        r_prio    <= n_prio;
        r_new_id  <= n_new_id;
        r_idx     <= n_idx;
        r_cur_id  <= n_cur_id;
        r_pend    <= n_pend;
        r_pend_id <= n_pend_id;
        r_cnt     <= n_cnt;
        r_next    <= n_next;
        r_single  <= n_single;
    end

    // order memory: read address follows the next index, so data lines up with r_idx
    always_ff @(posedge i_clk) begin
        if (ord_we) begin
            mem_ord[ord_waddr] <= ord_wdata;
        end
        r_ord_rd <= mem_ord[n_idx];
    end

    always_ff @(posedge i_clk) begin
        if (act_we) begin
            mem_act[act_waddr] <= act_wdata;
        end
        if (act_re) begin
            r_act_rd <= mem_act[rd_id];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/priority_timer_dispatcher_core.sv =====
// Top level of the priority timer dispatcher: request intake and result register.
//
// Usage: requests enter on i_in (valid/stall), one transaction per operation:
// add handler, reschedule handler, poll due handlers, query next wake time.
// Results leave on o_out (valid/stall); every request gives one result except
// a poll, which gives one per due handler (up to 16), or one none-due result
// if none is due, and flags the final one with last. A request is taken only
// while the sequencer is idle. An add shifts order memory entries up one slot,
// walking from the tail down to the insert point; a reschedule writes the
// activation memory; a poll or query reads, for each entry, the order memory
// and then the activation memory.
// Results pass through one output register, so the sequencer keeps working
// while a finished result waits. If the receiver stalls, the poll scan pauses
// at the next due handler until the register frees up; nothing is dropped.
// Reset empties the handler table (count to zero); memory contents are not
// cleared and entries are only read once written.
`timescale 1ns / 1ps
`default_nettype none

module priority_timer_dispatcher_core import ptd_pkg::*; #(
    parameter int MAX_HANDLERS = MAX_HANDLERS_DEF,
    parameter int TIME_BITS    = TIME_BITS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out
);

    logic      eng_ready;
    logic      res_valid;
    t_out_item res;
    logic      res_ready;
    logic      r_out_valid;
    t_out_item r_out;

    ptd_engine #(
        .MAX_HANDLERS (MAX_HANDLERS),
        .TIME_BITS    (TIME_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .i_item      (i_in),
        .o_ready     (eng_ready),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    assign o_in_stall = !eng_ready;
    assign res_ready  = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire
